// File: design/dfd_pkg.sv
// dmd frame decompressor package: decode phases, status codes, page geometry
// no dependencies
`default_nettype none
package dfd_pkg;
  localparam int PAGE_BYTES = 512;
  localparam int PAGE_ROWS  = 32;
  localparam int ROW_BYTES  = 16;
  localparam int PAW = $clog2(PAGE_BYTES);
  localparam int WPW = PAW + 1;
  localparam int RSW = $clog2(PAGE_ROWS);
  localparam int CSW = $clog2(ROW_BYTES);

  typedef enum logic [4:0] {
    PH_IDLE, PH_DONE, PH_BADTYPE, PH_RUNOUT, PH_RAW, PH_HFLAG, PH_HDICT,
    PH_SYM, PH_CNT, PH_VAL, PH_LSTART, PH_LFSKIP, PH_LCOUNT, PH_LLOAD, PH_LSKIP
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_BITS, ST_FILL, ST_READ, ST_OUT
  } seq_t;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;
endpackage
`default_nettype wire

// File: design/dmd_frame_decompressor_core.sv
// dmd frame decompressor core: byte-fed frame decoder with 512-byte page store
// depends on dfd_pkg
//
// usage: one request on in_* either feeds an encoded byte (in_operation 0) or
// reads a page byte (in_operation 1). every request gives exactly one result
// on out_*: read data, status, frame type and consumed byte count.
// path from accept to out_valid: a read passes ST_READ and ST_OUT, a plain byte goes
// to ST_OUT, a bit-stream byte shifts through ST_BITS one bit per cycle while no run
// fill runs, and stops early when the frame ends inside the byte. a run fill writes
// the page in ST_FILL, up to 512 writes. a type byte first clears the page store in
// ST_CLEAR, one entry per cycle.
// throughput: one request at a time, the next one after the result is taken.
// reset: control state clears; then a clearing pass runs over all 512 entries of the
// page store, during which in_ready stays low.
// stall: the result waits in the output register; the next request is taken
// only after the result has been taken.
`default_nettype none
module dmd_frame_decompressor_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_first_of_frame,
  input  wire logic        in_last_available,
  input  wire logic [8:0]  in_read_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_read_data,
  output logic [1:0]       out_status,
  output logic [3:0]       out_frame_type,
  output logic [11:0]      out_consumed_bytes
);
  import dfd_pkg::*;

  logic [7:0] page_mem [PAGE_BYTES];
  logic [7:0] dict_mem [8];

  seq_t seq_r, seq_nxt;
  phase_t ph_r, ph_nxt;
  logic [WPW-1:0] wpos_r, wpos_nxt;
  logic [WPW-1:0] clr_r, clr_nxt;
  logic [7:0] flag_r, flag_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [3:0] bcnt_r, bcnt_nxt;
  logic [8:0] run_r, run_nxt;
  logic [3:0] ftype_r, ftype_nxt;
  logic [11:0] bytes_r, bytes_nxt;
  logic in_bits_r, in_bits_nxt;
  logic [1:0] sym_r, sym_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic [3:0] shn_r, shn_nxt;
  logic last_r, last_nxt;
  logic [WPW-1:0] fill_n_r, fill_n_nxt;
  logic [7:0] fill_v_r, fill_v_nxt;
  logic [PAW-1:0] rd_idx_r;
  logic [7:0] rd_q_r;
  logic rd_hit_r;
  logic rd_op_r;
  logic out_valid_r;
  logic [7:0] out_rd_r;
  logic [7:0] out_rd_nxt;

  logic pw_en;
  logic [PAW-1:0] pw_addr;
  logic [7:0] pw_data;
  logic dw_en;
  logic [2:0] dw_addr;
  logic [7:0] dw_data;

  logic accept;
  logic colm;
  logic full;
  logic [PAW-1:0] put_idx;
  logic [7:0] val;
  logic val_en;
  logic bit_v;
  logic bit_abort;
  logic [3:0] t;

  assign accept = in_valid && in_ready;
  assign in_ready = (seq_r == ST_IDLE) && !out_valid_r;
  assign t = ftype_r;
  assign colm = (t == 4'd1) || (t == 4'd4) || (t == 4'd6) || (t == 4'd8) || (t == 4'd10);
  assign full = wpos_r >= WPW'(PAGE_BYTES);
  // column-major: row from low bits, column from high bits
  assign put_idx = colm ? PAW'({wpos_r[RSW-1:0], wpos_r[RSW+CSW-1:RSW]})
                        : wpos_r[PAW-1:0];

  always_ff @(posedge clk) begin
    if (pw_en) page_mem[pw_addr] <= pw_data;
    rd_q_r <= page_mem[rd_idx_r];
    if (dw_en) dict_mem[dw_addr] <= dw_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= ST_CLEAR;
      ph_r <= PH_IDLE;
      wpos_r <= '0;
      clr_r <= '0;
      flag_r <= '0;
      acc_r <= '0;
      bcnt_r <= '0;
      run_r <= '0;
      ftype_r <= '0;
      bytes_r <= '0;
      in_bits_r <= 1'b0;
      sym_r <= '0;
      shn_r <= '0;
      last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seq_r <= seq_nxt;
      ph_r <= ph_nxt;
      wpos_r <= wpos_nxt;
      clr_r <= clr_nxt;
      flag_r <= flag_nxt;
      acc_r <= acc_nxt;
      bcnt_r <= bcnt_nxt;
      run_r <= run_nxt;
      ftype_r <= ftype_nxt;
      bytes_r <= bytes_nxt;
      in_bits_r <= in_bits_nxt;
      sym_r <= sym_nxt;
      shn_r <= shn_nxt;
      last_r <= last_nxt;
      if (seq_r == ST_OUT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
    fill_n_r <= fill_n_nxt;
    fill_v_r <= fill_v_nxt;
    if (accept) begin
      rd_idx_r <= in_read_index[PAW-1:0];
      rd_hit_r <= {23'd0, in_read_index} < PAGE_BYTES;
    end
    if (seq_r == ST_OUT) out_rd_r <= out_rd_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) rd_op_r <= in_operation;
  end
  assign out_rd_nxt = (rd_op_r == OP_READ && rd_hit_r) ? rd_q_r : 8'd0;

  // value source in the bit stream path
  always_comb begin
    val = 8'd0;
    val_en = 1'b0;
    bit_v = sh_r[7];
    bit_abort = ph_r < PH_RAW;
    if (seq_r == ST_BITS && !bit_abort) begin
      unique case (sym_r)
        2'd1: begin
          val = {acc_r[6:0], bit_v};
          val_en = bcnt_r == 4'd7;
        end
        2'd2: begin
          if (bit_v) begin
            val = dict_mem[3'd7];
            val_en = bcnt_r == 4'd6;
          end else begin
            val = dict_mem[bcnt_r[2:0]];
            val_en = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // main sequencer
  always_comb begin
    logic [WPW-1:0] n;
    logic [7:0] b;
    logic [7:0] v;
    logic take;
    seq_nxt = seq_r;
    ph_nxt = ph_r;
    wpos_nxt = wpos_r;
    clr_nxt = clr_r;
    flag_nxt = flag_r;
    acc_nxt = acc_r;
    bcnt_nxt = bcnt_r;
    run_nxt = run_r;
    ftype_nxt = ftype_r;
    bytes_nxt = bytes_r;
    in_bits_nxt = in_bits_r;
    sym_nxt = sym_r;
    sh_nxt = sh_r;
    shn_nxt = shn_r;
    last_nxt = last_r;
    fill_n_nxt = fill_n_r;
    fill_v_nxt = fill_v_r;
    pw_en = 1'b0;
    pw_addr = put_idx;
    pw_data = 8'd0;
    dw_en = 1'b0;
    dw_addr = run_r[2:0];
    dw_data = in_data_byte;
    n = '0;
    b = in_data_byte;
    v = 8'd0;
    take = 1'b0;
    unique case (seq_r)
      ST_CLEAR: begin
        pw_en = 1'b1;
        pw_addr = clr_r[PAW-1:0];
        pw_data = 8'd0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == WPW'(PAGE_BYTES - 1)) begin
          clr_nxt = '0;
          seq_nxt = ST_IDLE;
          if (ph_r >= PH_RAW && last_r) ph_nxt = PH_RUNOUT;
          if (ph_r != PH_IDLE || ftype_r != 4'd0 || bytes_r != 12'd0) seq_nxt = ST_OUT;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          last_nxt = in_last_available;
          if (in_operation == OP_READ) begin
            seq_nxt = ST_READ;
          end else if (in_first_of_frame) begin
            ftype_nxt = b[3:0];
            wpos_nxt = '0;
            flag_nxt = '0;
            acc_nxt = '0;
            bcnt_nxt = '0;
            run_nxt = '0;
            in_bits_nxt = 1'b0;
            sym_nxt = '0;
            bytes_nxt = 12'd1;
            unique case (b[3:0])
              4'd0: ph_nxt = PH_RAW;
              4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd7: ph_nxt = PH_HFLAG;
              4'd8, 4'd9: ph_nxt = PH_LSTART;
              4'd10, 4'd11: ph_nxt = PH_HDICT;
              default: ph_nxt = PH_BADTYPE;
            endcase
            clr_nxt = '0;
            seq_nxt = ST_CLEAR;
          end else if (ph_r >= PH_RAW) begin
            if (bytes_r < 12'd4095) bytes_nxt = bytes_r + 1'b1;
            seq_nxt = ST_OUT;
            if (ph_r == PH_HFLAG) begin
              flag_nxt = b;
              if (t == 4'd4 || t == 4'd5) begin
                run_nxt = '0;
                ph_nxt = PH_HDICT;
              end else begin
                ph_nxt = PH_SYM;
              end
            end else if (ph_r == PH_HDICT) begin
              dw_en = 1'b1;
              run_nxt = run_r + 1'b1;
              if (run_r == 9'd7) begin
                in_bits_nxt = 1'b1;
                sym_nxt = '0;
                bcnt_nxt = '0;
                acc_nxt = '0;
                ph_nxt = (t == 4'd4 || t == 4'd5) ? PH_SYM : PH_LSTART;
              end
            end else if (in_bits_r) begin
              sh_nxt = b;
              shn_nxt = 4'd0;
              seq_nxt = ST_BITS;
            end else begin
              v = b;
              take = 1'b1;
            end
          end else begin
            seq_nxt = ST_OUT;
          end
        end
      end
      ST_BITS: begin
        sh_nxt = {sh_r[6:0], 1'b0};
        shn_nxt = shn_r + 1'b1;
        if (shn_r == 4'd7 || bit_abort) seq_nxt = ST_OUT;
        if (!bit_abort) begin
          unique case (sym_r)
            2'd0: begin
              bcnt_nxt = '0;
              acc_nxt = '0;
              sym_nxt = bit_v ? 2'd2 : 2'd1;
            end
            2'd1: begin
              acc_nxt = val;
              bcnt_nxt = bcnt_r + 1'b1;
              if (val_en) sym_nxt = '0;
            end
            default: begin
              if (bit_v) bcnt_nxt = bcnt_r + 1'b1;
              if (val_en) sym_nxt = '0;
            end
          endcase
          v = val;
          take = val_en;
        end
      end
      ST_FILL: begin
        if (fill_n_r == '0 || full) begin
          seq_nxt = in_bits_r && shn_r != 4'd0 && shn_r != 4'd8 && !(ph_r < PH_RAW)
                    ? ST_BITS : ST_OUT;
          if (ph_r == PH_VAL) ph_nxt = full ? PH_DONE : PH_SYM;
          else ph_nxt = full ? PH_DONE : PH_LCOUNT;
        end else begin
          pw_en = 1'b1;
          pw_data = fill_v_r;
          wpos_nxt = wpos_r + 1'b1;
          fill_n_nxt = fill_n_r - 1'b1;
        end
      end
      ST_READ: seq_nxt = ST_OUT;
      ST_OUT: begin
        seq_nxt = ST_IDLE;
      end
      default: seq_nxt = ST_IDLE;
    endcase

    if (take) begin
      unique case (ph_r)
        PH_RAW, PH_SYM, PH_LLOAD: begin
          if (ph_r == PH_SYM && v == flag_r) begin
            ph_nxt = PH_CNT;
          end else begin
            if (!full) begin
              pw_en = 1'b1;
              pw_data = v;
              wpos_nxt = wpos_r + 1'b1;
            end
            if (ph_r == PH_LLOAD) begin
              run_nxt = run_r - 1'b1;
              if (wpos_r >= WPW'(PAGE_BYTES - 1)) ph_nxt = PH_DONE;
              else if (run_r == 9'd1) ph_nxt = PH_LSKIP;
            end else if (wpos_r >= WPW'(PAGE_BYTES - 1)) begin
              ph_nxt = PH_DONE;
            end
          end
        end
        PH_CNT: begin
          run_nxt = {1'b0, v};
          ph_nxt = PH_VAL;
        end
        PH_VAL, PH_LFSKIP, PH_LSKIP: begin
          if (ph_r == PH_VAL) begin
            if (t == 4'd1 || t == 4'd2) n = (run_r == 9'd0) ? WPW'(256) : WPW'(run_r);
            else n = (run_r == 9'd0) ? WPW'(PAGE_BYTES) : WPW'(run_r);
            fill_v_nxt = (t == 4'd6 || t == 4'd7) ? 8'd0 : v;
          end else begin
            n = WPW'(v);
            fill_v_nxt = 8'd0;
          end
          ph_nxt = (ph_r == PH_VAL) ? PH_VAL : PH_LSKIP;
          fill_n_nxt = n;
          seq_nxt = ST_FILL;
        end
        PH_LSTART: ph_nxt = (v == 8'd0) ? PH_LFSKIP : PH_LCOUNT;
        PH_LCOUNT: begin
          if (v != 8'd0) begin
            run_nxt = {1'b0, v};
            ph_nxt = PH_LLOAD;
          end else begin
            ph_nxt = PH_LSKIP;
          end
        end
        default: ;
      endcase
    end

    if (seq_nxt == ST_OUT && seq_r != ST_OUT && seq_r != ST_CLEAR && seq_r != ST_READ
        && !(seq_r == ST_IDLE && accept && in_operation == OP_READ)) begin
      if (ph_nxt >= PH_RAW && last_nxt) ph_nxt = PH_RUNOUT;
    end
  end

  assign out_valid = out_valid_r;
  assign out_read_data = out_rd_r;
  assign out_status = (ph_r < PH_RAW) ? ph_r[1:0] : 2'd0;
  assign out_frame_type = ftype_r;
  assign out_consumed_bytes = bytes_r;

  property p_no_accept_busy;
    @(posedge clk) disable iff (!rst_n) (seq_r != ST_IDLE) |-> !in_ready;
  endproperty
  assert property (p_no_accept_busy) else $error("request taken while busy");

  property p_out_once;
    @(posedge clk) disable iff (!rst_n) (out_valid && !out_ready) |=> out_valid;
  endproperty
  assert property (p_out_once) else $error("result dropped");

  property p_fill_bound;
    @(posedge clk) disable iff (!rst_n) (seq_r == ST_FILL) |-> (wpos_r <= WPW'(PAGE_BYTES));
  endproperty
  assert property (p_fill_bound) else $error("write position beyond page");
endmodule
`default_nettype wire
